/* rtl/core/wssr_pkg.sv */
// wssr_pkg: constants, widths, register indexes and controller/datapath
// interface structs for the windowed wssr anomaly test
// no dependencies
package wssr_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_ROWS   = 16;

    localparam int E_W     = 32;
    localparam int SQ_W    = 2 * E_W;
    localparam int SUM_W   = 40;
    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int TOT_W   = SUM_W + PTR_W;
    localparam int WIN_W   = 7;
    localparam int ROWS_W  = 5;
    localparam int SIGMA_W = 16;
    localparam int SIGMA_FRAC = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DAT_W  = 16;

    // quotient bits above the fraction that still fit the 40-bit result
    localparam int QINT_W  = SUM_W - FRAC_BITS;
    localparam int DIV_CYCLES = SUM_W / 2;
    localparam int DCNT_W  = $clog2(DIV_CYCLES + 1);

    // sqrt operand is 2*M*L scaled by 2^(2*FRAC_BITS)
    localparam int ML_W    = $clog2(MAX_WINDOW * MAX_ROWS + 1);
    localparam int X_W     = ML_W + 1 + 2 * FRAC_BITS;
    localparam int S_W     = X_W / 2;
    localparam int SQRT_CYCLES = S_W / 2 + S_W % 2;
    localparam int SCNT_W  = $clog2(SQRT_CYCLES + 1);
    localparam int TH_W    = S_W + SIGMA_W - SIGMA_FRAC;
    localparam int BASE_W  = ML_W + FRAC_BITS;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STEPS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_STEP = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_SIGMA   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_SIGMA   = 8'd3;

    localparam logic [WIN_W-1:0]   WIN_RESET   = 7'd16;
    localparam logic [ROWS_W-1:0]  ROWS_RESET  = 5'd1;
    localparam logic [SIGMA_W-1:0] UPPER_RESET = 16'd768;
    localparam logic [SIGMA_W-1:0] LOWER_RESET = 16'd256;

    typedef struct packed {
        logic capture;
        logic square;
        logic div_init;
        logic div_step;
        logic accum;
        logic ring;
        logic mul;
        logic load;
    } wssr_cmd_t;

    typedef struct packed {
        logic last;
        logic full;
    } wssr_sts_t;

endpackage

/* rtl/core/windowed_wssr_anomaly_test.sv */
// a row is added to its step sum after its transfer through the states square,
// divider setup and the radix-4 divider (two quotient bits a cycle) and accumulate
// the input takes no new row until the previous row is through; a row that ends a step
// also writes the step ring; a result row then runs the threshold stage and emit
// an unread result holds the next one in emit, and the input with it
// async active-low reset: config to defaults, window empty, no result pending
module windowed_wssr_anomaly_test
    import wssr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // innovation[31:0], innovation_variance[63:32]
    input  logic                 s_tlast,   // last_row
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [127:0]         m_tdata,   // wssr[39:0], upper_threshold[79:40],
                                            // lower_threshold[119:80], above_upper[120],
                                            // below_lower[121], zeros[127:122]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    wssr_cmd_t cmd;
    wssr_sts_t sts;

    assign cfg_ready = 1'b1;

    wssr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wssr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

/* rtl/core/wssr_ctrl.sv */
// wssr_ctrl: sequencer for one innovation row and the per-step result
// depends on wssr_pkg; drives wssr_dp through wssr_cmd_t
module wssr_ctrl
    import wssr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  wssr_sts_t sts,
    output wssr_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_DIV_INIT,
        ST_DIV,
        ST_ACCUM,
        ST_RING,
        ST_MUL,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              mv_reg, mv_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.square   = (state_reg == ST_SQUARE);
        cmd.div_init = (state_reg == ST_DIV_INIT);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.accum    = (state_reg == ST_ACCUM);
        cmd.ring     = (state_reg == ST_RING);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.load     = (state_reg == ST_EMIT) && (!mv_reg || m_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg;
        if (m_tready)
        begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cnt_next   = DCNT_W'(DIV_CYCLES - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                state_next = sts.last ? ST_RING : ST_IDLE;
            end
            ST_RING:
            begin
                state_next = sts.full ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // wait for the output register to drain
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

`ifndef SYNTH
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!mv_reg || m_tready))
        else $error("result loaded over an unread result");
    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mv_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output valid rose outside emit");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_INIT) |=> ##(DIV_CYCLES) (state_reg == ST_ACCUM))
        else $error("divider ran the wrong number of cycles");
`endif

endmodule

/* rtl/core/wssr_dp.sv */
// wssr_dp: datapath with squarer, radix-4 divider, sqrt unit, step ring
// memory, window total, thresholds and output register; holds the config
// depends on wssr_pkg; sequenced by wssr_ctrl
module wssr_dp
    import wssr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  wssr_cmd_t            cmd,
    output wssr_sts_t            sts,
    input  logic [2*E_W-1:0]     s_tdata,
    input  logic                 s_tlast,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic [127:0]         m_tdata
);

    // config
    logic [WIN_W-1:0]   ws_reg;
    logic [ROWS_W-1:0]  rps_reg;
    logic [SIGMA_W-1:0] us_reg, ls_reg;

    // row registers
    logic [E_W-1:0]   e_reg, v_reg;
    logic             last_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic             sat_reg;
    logic [E_W-1:0]   rem_reg;
    logic [SUM_W-1:0] dsh_reg, q_reg;

    // sqrt unit
    logic [X_W-1:0]    sx_reg, sr_reg, sb_reg;
    logic [SCNT_W-1:0] scnt_reg;

    // step state
    logic [SUM_W-1:0] cur_reg;
    logic [TOT_W-1:0] total_reg;
    logic [CNT_W-1:0] filled_reg;
    logic [PTR_W-1:0] ptr_reg;
    logic [SUM_W-1:0] mem [MAX_WINDOW];
    logic [SUM_W-1:0] rd_reg;

    // threshold stage
    logic [TH_W-1:0]   tu_reg, tl_reg;
    logic [BASE_W-1:0] base_reg;
    logic [SUM_W-1:0]  wssr_reg;

    // output payload
    logic [SUM_W-1:0] o_wssr_reg, o_up_reg, o_lo_reg;
    logic             o_above_reg, o_below_reg;

    logic [CNT_W-1:0]  l_eff;
    logic [ROWS_W-1:0] m_eff;
    logic [ML_W-1:0]   ml;
    logic [PTR_W-1:0]  ptr_eff;
    logic [CNT_W-1:0]  ptr_inc;
    logic [CNT_W-1:0]  filled_inc;
    logic [E_W-1:0]    mag;
    logic [SQ_W-1:0]   sq_prod;
    logic [E_W:0]      div_a, div_b;
    logic [2*X_W-1:0]  sq_a, sq_b;
    logic [SUM_W-1:0]  term;
    logic [SUM_W:0]    cur_sum;
    logic [TOT_W-1:0]  total_next;
    logic [S_W+SIGMA_W-1:0] pu, pl;
    logic [SUM_W:0]    up_sum;
    logic [SUM_W-1:0]  up_val, lo_val;
    logic [SUM_W-1:0]  base_ext, tl_ext;

    // one restoring divider step: returns {quotient bit, remainder}
    function automatic logic [E_W:0] div_bit(input logic [E_W-1:0] rem,
                                             input logic b,
                                             input logic [E_W-1:0] d);
        logic [E_W:0] r2;
        logic [E_W:0] diff;
        r2   = {rem, b};
        diff = r2 - {1'b0, d};
        if (r2 >= {1'b0, d})
        begin
            return {1'b1, diff[E_W-1:0]};
        end
        return {1'b0, r2[E_W-1:0]};
    endfunction

    // one digit of the bitwise integer sqrt: returns {x, res}
    function automatic logic [2*X_W-1:0] sqrt_bit(input logic [X_W-1:0] x,
                                                  input logic [X_W-1:0] r,
                                                  input logic [X_W-1:0] b);
        logic [X_W-1:0] rb;
        rb = r + b;
        if (x >= rb)
        begin
            return {x - rb, (r >> 1) + b};
        end
        return {x, r >> 1};
    endfunction

    always_comb
    begin
        if (ws_reg == '0)
        begin
            l_eff = CNT_W'(1);
        end
        else if (ws_reg > WIN_W'(MAX_WINDOW))
        begin
            l_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            l_eff = CNT_W'(ws_reg);
        end
        if (rps_reg == '0)
        begin
            m_eff = ROWS_W'(1);
        end
        else if (rps_reg > ROWS_W'(MAX_ROWS))
        begin
            m_eff = ROWS_W'(MAX_ROWS);
        end
        else
        begin
            m_eff = rps_reg;
        end
    end

    assign ml         = ML_W'(m_eff) * ML_W'(l_eff);
    assign ptr_eff    = (CNT_W'(ptr_reg) >= l_eff) ? '0 : ptr_reg;
    assign ptr_inc    = CNT_W'(ptr_eff) + 1'b1;
    assign filled_inc = (filled_reg < l_eff) ? filled_reg + 1'b1 : filled_reg;

    assign mag     = e_reg[E_W-1] ? (~e_reg + 1'b1) : e_reg;
    assign sq_prod = mag * mag;

    assign div_a = div_bit(rem_reg, dsh_reg[SUM_W-1], v_reg);
    assign div_b = div_bit(div_a[E_W-1:0], dsh_reg[SUM_W-2], v_reg);
    assign sq_a  = sqrt_bit(sx_reg, sr_reg, sb_reg);
    assign sq_b  = sqrt_bit(sq_a[2*X_W-1:X_W], sq_a[X_W-1:0], sb_reg >> 2);

    assign term    = sat_reg ? SUM_MAX : q_reg;
    assign cur_sum = {1'b0, cur_reg} + {1'b0, term};

    assign total_next = total_reg + TOT_W'(cur_reg)
                        - ((filled_reg >= l_eff) ? TOT_W'(rd_reg) : '0);

    assign pu = us_reg * sr_reg[S_W-1:0];
    assign pl = ls_reg * sr_reg[S_W-1:0];

    assign base_ext = SUM_W'(base_reg);
    assign tl_ext   = SUM_W'(tl_reg);
    assign up_sum   = (SUM_W+1)'(base_reg) + (SUM_W+1)'(tu_reg);
    assign up_val   = up_sum[SUM_W] ? SUM_MAX : up_sum[SUM_W-1:0];
    assign lo_val   = (base_ext > tl_ext) ? base_ext - tl_ext : '0;

    assign sts.last = last_reg;
    assign sts.full = (filled_inc >= l_eff);

    assign m_tdata = {6'b0, o_below_reg, o_above_reg, o_lo_reg, o_up_reg, o_wssr_reg};

    // config, window state and the sqrt iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg     <= WIN_RESET;
            rps_reg    <= ROWS_RESET;
            us_reg     <= UPPER_RESET;
            ls_reg     <= LOWER_RESET;
            cur_reg    <= '0;
            total_reg  <= '0;
            filled_reg <= '0;
            ptr_reg    <= '0;
            scnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_WINDOW_STEPS:
                    begin
                        ws_reg     <= cfg_data[WIN_W-1:0];
                        filled_reg <= '0;
                        total_reg  <= '0;
                        ptr_reg    <= '0;
                    end
                    CFG_ROWS_PER_STEP: rps_reg <= cfg_data[ROWS_W-1:0];
                    CFG_UPPER_SIGMA:   us_reg  <= cfg_data;
                    CFG_LOWER_SIGMA:   ls_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.accum)
            begin
                cur_reg <= cur_sum[SUM_W] ? SUM_MAX : cur_sum[SUM_W-1:0];
            end
            if (cmd.ring)
            begin
                total_reg  <= total_next;
                filled_reg <= filled_inc;
                ptr_reg    <= (ptr_inc >= l_eff) ? '0 : ptr_inc[PTR_W-1:0];
                cur_reg    <= '0;
            end
            if (cmd.square)
            begin
                scnt_reg <= SCNT_W'(SQRT_CYCLES);
            end
            else if (scnt_reg != '0)
            begin
                scnt_reg <= scnt_reg - 1'b1;
            end
        end
    end

    // row payload, divider and sqrt iterations, threshold stage and output register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            e_reg    <= s_tdata[E_W-1:0];
            v_reg    <= (s_tdata[2*E_W-1:E_W] == '0) ? E_W'(1) : s_tdata[2*E_W-1:E_W];
            last_reg <= s_tlast;
        end
        if (cmd.square)
        begin
            sq_reg <= sq_prod;
            sx_reg <= X_W'({ml, 1'b0}) << (2 * FRAC_BITS);
            sr_reg <= '0;
            sb_reg <= X_W'(1) << (X_W - 2);
        end
        else if (scnt_reg != '0)
        begin
            sx_reg <= sq_b[2*X_W-1:X_W];
            sr_reg <= sq_b[X_W-1:0];
            sb_reg <= sb_reg >> 4;
        end
        if (cmd.div_init)
        begin
            // quotient of 2^40 or more saturates
            sat_reg <= (sq_reg[SQ_W-1:QINT_W] >= (SQ_W-QINT_W)'(v_reg));
            rem_reg <= sq_reg[QINT_W+E_W-1:QINT_W];
            dsh_reg <= {sq_reg[QINT_W-1:0], {FRAC_BITS{1'b0}}};
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_b[E_W-1:0];
            dsh_reg <= dsh_reg << 2;
            q_reg   <= {q_reg[SUM_W-3:0], div_a[E_W], div_b[E_W]};
        end
        if (cmd.mul)
        begin
            tu_reg   <= pu[S_W+SIGMA_W-1:SIGMA_FRAC];
            tl_reg   <= pl[S_W+SIGMA_W-1:SIGMA_FRAC];
            base_reg <= BASE_W'(ml) << FRAC_BITS;
            wssr_reg <= (total_reg > TOT_W'(SUM_MAX)) ? SUM_MAX : total_reg[SUM_W-1:0];
        end
        if (cmd.load)
        begin
            o_wssr_reg  <= wssr_reg;
            o_up_reg    <= up_val;
            o_lo_reg    <= lo_val;
            o_above_reg <= (wssr_reg > up_val);
            o_below_reg <= (wssr_reg < lo_val);
        end
    end

    // step ring, registered read at the current slot
    always_ff @(posedge clk)
    begin
        if (cmd.ring)
        begin
            mem[ptr_eff] <= cur_reg;
        end
        rd_reg <= mem[ptr_eff];
    end

`ifndef SYNTH
    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= l_eff)
        else $error("window fill count beyond window length");
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ring |=> (CNT_W'(ptr_reg) < l_eff))
        else $error("ring pointer left the window");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && !sat_reg) |-> (rem_reg < v_reg))
        else $error("divider remainder not below divisor");
    a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> (scnt_reg == '0))
        else $error("sqrt still running at threshold stage");
`endif

endmodule

/* test/tb_windowed_wssr_anomaly_test.sv */
// testbench for windowed_wssr_anomaly_test: streams innovation rows through the
// block under several register settings and checks every window result against
// its own prediction of the step sums, window total and thresholds; uses wssr_pkg
module tb_windowed_wssr_anomaly_test;
    import wssr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD    = 600;

    typedef struct {
        logic [31:0] innovation;
        logic [31:0] variance;
        logic        last;
        int unsigned idle_before;
    } row_t;

    typedef struct packed {
        logic [SUM_W-1:0] wssr;
        logic [SUM_W-1:0] upper;
        logic [SUM_W-1:0] lower;
        logic             above;
        logic             below;
    } verdict_t;

    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;    // innovation[31:0], innovation_variance[63:32]
    logic                 s_tlast = 1'b0;  // last_row
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [127:0]         m_tdata;         // wssr[39:0], upper_threshold[79:40],
                                           // lower_threshold[119:80], above_upper[120],
                                           // below_lower[121]
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    windowed_wssr_anomaly_test DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predicted block state
    logic [SUM_W-1:0]   window_ring [MAX_WINDOW];
    logic [63:0]        ring_total;
    logic [SUM_W-1:0]   open_step_sum;
    int unsigned        steps_held;
    int unsigned        ring_slot;
    logic [WIN_W-1:0]   reg_window;
    logic [ROWS_W-1:0]  reg_rows;
    logic [SIGMA_W-1:0] reg_upper_sigma;
    logic [SIGMA_W-1:0] reg_lower_sigma;

    row_t     row_queue[$];
    verdict_t pending_verdicts[$];
    row_t     queued_row;

    int       mismatch_count = 0;
    int       results_seen = 0;
    int       long_hold_left = 0;
    int       rx_mode_left = 0;
    rx_mode_e rx_mode = RX_ALWAYS;
    int       idle_cycles = 0;

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // e*e/v in Q24.16 with the variance floored at one
    function automatic logic [SUM_W-1:0] weighted_square(logic [31:0] e, logic [31:0] v);
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] sq;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] t;
        mag = e[31] ? (64'h1_0000_0000 - {32'd0, e}) : {32'd0, e};
        den = (v == '0) ? 64'd1 : {32'd0, v};
        sq  = mag * mag;
        quo = sq / den;
        rem = sq % den;
        if (quo > (64'(SUM_MAX) >> FRAC_BITS))
            return SUM_MAX;
        t = (quo << FRAC_BITS) + ((rem << FRAC_BITS) / den);
        return (t > 64'(SUM_MAX)) ? SUM_MAX : t[SUM_W-1:0];
    endfunction

    task automatic absorb_row(logic [31:0] e, logic [31:0] v, logic last);
        int unsigned l;
        logic [63:0] m;
        logic [63:0] ml;
        logic [63:0] s;
        logic [63:0] tu;
        logic [63:0] tl;
        logic [63:0] base;
        logic [63:0] up;
        logic [63:0] sum;
        verdict_t    vd;
        l = (reg_window == '0) ? 1 : (reg_window > MAX_WINDOW) ? MAX_WINDOW : reg_window;
        sum = 64'(open_step_sum) + 64'(weighted_square(e, v));
        open_step_sum = (sum > 64'(SUM_MAX)) ? SUM_MAX : sum[SUM_W-1:0];
        if (!last)
            return;
        if (ring_slot >= l)
            ring_slot = 0;
        if (steps_held >= l)
            ring_total -= 64'(window_ring[ring_slot]);
        window_ring[ring_slot] = open_step_sum;
        ring_total += 64'(open_step_sum);
        ring_slot = (ring_slot + 1 >= l) ? 0 : ring_slot + 1;
        if (steps_held < l)
            steps_held++;
        open_step_sum = '0;
        if (steps_held < l)
            return;
        m = (reg_rows == '0) ? 64'd1 : (reg_rows > MAX_ROWS) ? 64'(MAX_ROWS) : 64'(reg_rows);
        ml = m * 64'(l);
        s = floor_sqrt((2 * ml) << (2 * FRAC_BITS));
        tu = (64'(reg_upper_sigma) * s) >> SIGMA_FRAC;
        tl = (64'(reg_lower_sigma) * s) >> SIGMA_FRAC;
        base = ml << FRAC_BITS;
        vd.wssr = (ring_total > 64'(SUM_MAX)) ? SUM_MAX : ring_total[SUM_W-1:0];
        up = base + tu;
        vd.upper = (up > 64'(SUM_MAX)) ? SUM_MAX : up[SUM_W-1:0];
        vd.lower = (base > tl) ? SUM_W'(base - tl) : '0;
        vd.above = vd.wssr > vd.upper;
        vd.below = vd.wssr < vd.lower;
        pending_verdicts.insert(pending_verdicts.size(), vd);
    endtask

    // sender: one row per transfer, idle gaps taken from the head of the queue
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                absorb_row(s_tdata[31:0], s_tdata[63:32], s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (row_queue.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                end
                else if (row_queue[0].idle_before != 0)
                begin
                    row_queue[0].idle_before--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    queued_row = row_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {queued_row.variance, queued_row.innovation};
                    s_tlast  <= queued_row.last;
                end
            end
        end
    end

    // receiver: compare each result transfer, stall on a pattern of its own
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result wssr %h", m_tdata[39:0]);
                end
                else
                begin
                    verdict_t want;
                    verdict_t got;
                    want = pending_verdicts.pop_front();
                    got.wssr  = m_tdata[39:0];
                    got.upper = m_tdata[79:40];
                    got.lower = m_tdata[119:80];
                    got.above = m_tdata[120];
                    got.below = m_tdata[121];
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result %0d: wssr %h/%h upper %h/%h lower %h/%h flags %b%b/%b%b",
                                     results_seen, want.wssr, got.wssr, want.upper, got.upper,
                                     want.lower, got.lower, want.above, want.below,
                                     got.above, got.below);
                    end
                end
                results_seen++;
                // long hold-off so the block backs up into its input
                if (results_seen % 150 == 25)
                    long_hold_left = LONG_HOLD;
            end
            if (rx_mode_left == 0)
            begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 200);
            end
            else
            begin
                rx_mode_left--;
            end
            if (long_hold_left != 0)
            begin
                long_hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:   m_tready <= 1'b1;
                    RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 15) == 0);
                    RX_PERIODIC: m_tready <= (rx_mode_left % 8 < 3);
                    default:     m_tready <= 1'b1;
                endcase
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WINDOW_STEPS:
            begin
                // window restarts, the open step sum survives
                reg_window = value[WIN_W-1:0];
                steps_held = 0;
                ring_total = '0;
                ring_slot  = 0;
            end
            CFG_ROWS_PER_STEP: reg_rows = value[ROWS_W-1:0];
            CFG_UPPER_SIGMA:   reg_upper_sigma = value;
            CFG_LOWER_SIGMA:   reg_lower_sigma = value;
            default: ;
        endcase
    endtask

    task automatic push_row(logic [31:0] e, logic [31:0] v, logic last);
        row_t r;
        r.innovation  = e;
        r.variance    = v;
        r.last        = last;
        r.idle_before = 0;
        row_queue.insert(row_queue.size(), r);
    endtask

    function automatic row_t random_row(int unsigned scale);
        row_t        r;
        logic [63:0] sd;
        logic [63:0] mag;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        r.idle_before = 0;
        r.last = 1'b0;
        if (pick < 15)
        begin
            // residual roughly scaled to the standard deviation
            r.variance = $urandom >> $urandom_range(0, 31);
            if (r.variance == '0)
                r.variance = 32'd1;
            sd = floor_sqrt({32'd0, r.variance});
            mag = (sd * scale * $urandom_range(0, 256)) >> 8;
            r.innovation = $urandom_range(0, 1) ? -mag[31:0] : mag[31:0];
        end
        else if (pick < 17)
        begin
            r.innovation = $urandom;
            r.variance   = $urandom;
        end
        else if (pick < 19)
        begin
            r.innovation = $urandom;
            r.variance   = $urandom_range(0, 3);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       r.innovation = 32'h8000_0000;
                1:       r.innovation = 32'h7FFF_FFFF;
                2:       r.innovation = 32'hFFFF_FFFF;
                default: r.innovation = 32'h0000_0000;
            endcase
            r.variance = $urandom;
        end
        return r;
    endfunction

    task automatic queue_random_rows(int n, bit with_gaps);
        int unsigned step_left;
        int unsigned scale;
        int unsigned burst_left;
        row_t        r;
        step_left  = 0;
        burst_left = 0;
        scale      = 0;
        for (int i = 0; i < n; i++)
        begin
            if (step_left == 0)
            begin
                step_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                        : $urandom_range(1, 3);
                scale = $urandom_range(0, 4);
            end
            r = random_row(scale);
            step_left--;
            r.last = (step_left == 0);
            // occasional broken step boundary
            if ($urandom_range(0, 31) == 0)
                r.last = ~r.last;
            if (with_gaps)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    r.idle_before = $urandom_range(1, 60);
                end
                burst_left--;
            end
            row_queue.insert(row_queue.size(), r);
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (row_queue.size() != 0 || s_tvalid || pending_verdicts.size() != 0);
        // rows that end no step may still be in the divider
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic [15:0] win, logic [15:0] rows, logic [15:0] usig,
                             logic [15:0] lsig, int n, bit with_gaps);
        write_register(CFG_WINDOW_STEPS, win);
        write_register(CFG_ROWS_PER_STEP, rows);
        write_register(CFG_UPPER_SIGMA, usig);
        write_register(CFG_LOWER_SIGMA, lsig);
        @(negedge clk);
        queue_random_rows(n, with_gaps);
        wait_drained();
    endtask

    initial
    begin
        ring_total      = '0;
        open_step_sum   = '0;
        steps_held      = 0;
        ring_slot       = 0;
        reg_window      = WIN_RESET;
        reg_rows        = ROWS_RESET;
        reg_upper_sigma = UPPER_RESET;
        reg_lower_sigma = LOWER_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zero and floored variance, saturating terms and step sums
        push_row(32'h0000_0000, 32'h0000_0000, 1'b1);
        push_row(32'h8000_0000, 32'h0000_0000, 1'b1);
        push_row(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_row(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
        push_row(32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
        push_row(32'h0000_0003, 32'h0000_0002, 1'b1);
        push_row(32'd1000, 32'd1000000, 1'b1);
        push_row(-32'd1000, 32'd999999, 1'b1);
        push_row(32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        push_row(32'h8000_0000, 32'h0000_0001, 1'b0);
        push_row(32'd12345, 32'h0000_0000, 1'b1);
        push_row(32'h0000_FFFF, 32'h0001_0000, 1'b1);
        push_row(32'hFFFF_0000, 32'h8000_0000, 1'b1);
        push_row(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        push_row(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        push_row(32'h0000_0007, 32'h0000_0000, 1'b1);
        push_row(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        push_row(32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        push_row(32'h0000_0001, 32'h0000_0001, 1'b1);
        push_row(32'h0000_0000, 32'h0000_0000, 1'b1);
        push_row(32'h7FFF_FFFF, 32'h0000_0002, 1'b1);
        // open step carried across the next window restart
        push_row(-32'd5, 32'h0000_0003, 1'b0);
        wait_drained();

        run_phase(16'd1, 16'd1, 16'd768, 16'd256, 150, 1'b1);
        // zero window and rows act as one, zero sigmas
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 120, 1'b1);
        // widest window, no sender gaps, lower threshold clamps at zero
        run_phase(16'd64, 16'd16, 16'd65535, 16'd65535, 260, 1'b0);
        // out-of-range window and rows
        run_phase(16'd127, 16'd31, 16'd1, 16'd1, 200, 1'b1);
        run_phase(16'd65, 16'd2, 16'd300, 16'd200, 100, 1'b1);
        repeat (3)
            run_phase(16'($urandom_range(1, 8)), 16'($urandom_range(1, 16)),
                      16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 90, 1'b1);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/wssr_pkg.sv
rtl/core/wssr_ctrl.sv
rtl/core/wssr_dp.sv
rtl/core/windowed_wssr_anomaly_test.sv
test/tb_windowed_wssr_anomaly_test.sv
